[sv/slx_pkg.sv]
// Shared types, codes and keyword table of the source text lexer.
package slx_pkg;

    // record kinds
    localparam logic [1:0] REC_TEXT  = 2'd0;
    localparam logic [1:0] REC_TOKEN = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd0;
    localparam logic [2:0] ERR_NEWLINE       = 3'd1;
    localparam logic [2:0] ERR_TAB           = 3'd2;
    localparam logic [2:0] ERR_UNTERMINATED  = 3'd3;
    localparam logic [2:0] ERR_NOT_SINGLE    = 3'd4;
    localparam logic [2:0] ERR_INVALID       = 3'd5;

    // token numbers
    localparam logic [6:0] TOK_EOF        = 7'd0;
    localparam logic [6:0] TOK_COMMA      = 7'd1;
    localparam logic [6:0] TOK_SEMI       = 7'd2;
    localparam logic [6:0] TOK_TILDE      = 7'd3;
    localparam logic [6:0] TOK_TILDE2     = 7'd4;
    localparam logic [6:0] TOK_LPAREN     = 7'd5;
    localparam logic [6:0] TOK_RPAREN     = 7'd6;
    localparam logic [6:0] TOK_LBRACE     = 7'd7;
    localparam logic [6:0] TOK_RBRACE     = 7'd8;
    localparam logic [6:0] TOK_LBRACK     = 7'd9;
    localparam logic [6:0] TOK_RBRACK     = 7'd10;
    localparam logic [6:0] TOK_MINUS      = 7'd11;
    localparam logic [6:0] TOK_MINUS_EQ   = 7'd12;
    localparam logic [6:0] TOK_ARROW      = 7'd13;
    localparam logic [6:0] TOK_PLUS       = 7'd14;
    localparam logic [6:0] TOK_PLUS_EQ    = 7'd15;
    localparam logic [6:0] TOK_STAR       = 7'd16;
    localparam logic [6:0] TOK_POW        = 7'd17;
    localparam logic [6:0] TOK_POW_EQ     = 7'd18;
    localparam logic [6:0] TOK_STAR_EQ    = 7'd19;
    localparam logic [6:0] TOK_SLASH      = 7'd20;
    localparam logic [6:0] TOK_SLASH_EQ   = 7'd21;
    localparam logic [6:0] TOK_PERCENT    = 7'd22;
    localparam logic [6:0] TOK_PERCENT_EQ = 7'd23;
    localparam logic [6:0] TOK_AMP        = 7'd24;
    localparam logic [6:0] TOK_AMP2       = 7'd25;
    localparam logic [6:0] TOK_AMP_EQ     = 7'd26;
    localparam logic [6:0] TOK_PIPE       = 7'd27;
    localparam logic [6:0] TOK_PIPE2      = 7'd28;
    localparam logic [6:0] TOK_PIPE_EQ    = 7'd29;
    localparam logic [6:0] TOK_CARET      = 7'd30;
    localparam logic [6:0] TOK_CARET_EQ   = 7'd31;
    localparam logic [6:0] TOK_UNDERSCORE = 7'd32;
    localparam logic [6:0] TOK_AT         = 7'd33;
    localparam logic [6:0] TOK_ASSIGN     = 7'd34;
    localparam logic [6:0] TOK_EQ         = 7'd35;
    localparam logic [6:0] TOK_FAT_ARROW  = 7'd36;
    localparam logic [6:0] TOK_LT         = 7'd37;
    localparam logic [6:0] TOK_SHL        = 7'd38;
    localparam logic [6:0] TOK_SHL_EQ     = 7'd39;
    localparam logic [6:0] TOK_LE         = 7'd40;
    localparam logic [6:0] TOK_SPACESHIP  = 7'd41;
    localparam logic [6:0] TOK_GT         = 7'd42;
    localparam logic [6:0] TOK_SHR        = 7'd43;
    localparam logic [6:0] TOK_SHR_EQ     = 7'd44;
    localparam logic [6:0] TOK_GE         = 7'd45;
    localparam logic [6:0] TOK_BANG       = 7'd46;
    localparam logic [6:0] TOK_NE         = 7'd47;
    localparam logic [6:0] TOK_BANG_TILDE = 7'd48;
    localparam logic [6:0] TOK_QUESTION   = 7'd49;
    localparam logic [6:0] TOK_STRING     = 7'd50;
    localparam logic [6:0] TOK_CHAR       = 7'd51;
    localparam logic [6:0] TOK_DOT        = 7'd52;
    localparam logic [6:0] TOK_COLON      = 7'd53;
    localparam logic [6:0] TOK_SCOPE      = 7'd54;
    localparam logic [6:0] TOK_IDENT      = 7'd55;
    localparam logic [6:0] TOK_INT        = 7'd56;
    localparam logic [6:0] TOK_HEX        = 7'd57;
    localparam logic [6:0] TOK_BIN        = 7'd58;
    localparam logic [6:0] TOK_FLOAT      = 7'd59;
    localparam logic [6:0] TOK_KW_BASE    = 7'd60;

    // control characters
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // keywords, right-justified, with their lengths
    localparam int NUM_KW = 23;
    localparam logic [127:0] KW_TEXT [NUM_KW] = '{
        128'("function"), 128'("lambda"), 128'("while"), 128'("for"),
        128'("return"), 128'("var"), 128'("if"), 128'("else"),
        128'("true"), 128'("false"), 128'("namespace"), 128'("except"),
        128'("throw"), 128'("null"), 128'("iife"), 128'({"build", "_in"}),
        128'("enum"), 128'("define"), 128'("preset"), 128'("switch"),
        128'("choose"), 128'("case"), 128'("default")
    };
    localparam int KW_LEN [NUM_KW] = '{
        8, 6, 5, 3, 6, 3, 2, 4, 4, 5, 9, 6, 5, 4, 4, 8, 4, 6, 6, 6, 6, 4, 7
    };

    // byte at position pos of keyword k, zero past its end
    function automatic logic [7:0] kw_byte(int k, int pos);
        int sh;
        logic [127:0] t;
        sh = 8 * (KW_LEN[k] - 1 - pos);
        t = '0;
        if (sh >= 0)
        begin
            t = KW_TEXT[k] >> sh;
        end
        return t[7:0];
    endfunction

    // one result record, without line number
    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] tok;
        logic [7:0] ch;
        logic [2:0] err;
    } rec_t;

    // all records caused by one request
    localparam int NUM_RECS = 3;
    typedef struct packed {
        logic [1:0]              count;
        rec_t [NUM_RECS-1:0]     recs;
        logic [23:0]             line;
    } bundle_t;

endpackage

[sv/source_text_lexer.sv]
// Top level of the source text lexer: front, bundle queue and emitter.
//
//   channel  | handshake                 | payload
//   in       | in_valid / in_stall        | source_byte, end_of_input
//   out      | out_valid / out_stall      | record_kind .. last_of_item
//   cfg      | cfg_write                 | cfg_data (start_line)
//
// A request is lexed in the cycle it is taken and its records, if any (up to
// 3), are queued as one bundle; the first record goes through the bundle queue
// and the emitter's bundle register to the output, and the rest follow one per
// cycle while out_stall is low, with no gap between bundles. The input takes one
// request per cycle unless the queue is full; in_stall rises only while it is full.
// Reset leaves the lexer at start of text with line count 1; an error
// freezes the lexer until the next reset.
module source_text_lexer #(
    parameter int KEYWORD_MAX_LEN = 9,
    parameter int LINE_BITS = 24,
    parameter int RESULT_QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  source_byte,
    input  logic        end_of_input,
    input  logic        cfg_write,
    input  logic [23:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  record_kind,
    output logic [6:0]  token_kind,
    output logic [7:0]  text_char,
    output logic [2:0]  error_code,
    output logic [23:0] line_number,
    output logic        last_of_item
);

    logic             take, push, pop, empty, full;
    slx_pkg::bundle_t push_data, head;

    assign in_stall = full;
    assign take     = in_valid && !full;

    slx_front #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .LINE_BITS       (LINE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .source_byte  (source_byte),
        .end_of_input (end_of_input),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .push         (push),
        .push_data    (push_data)
    );

    slx_queue #(
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    slx_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .token_kind   (token_kind),
        .text_char    (text_char),
        .error_code   (error_code),
        .line_number  (line_number),
        .last_of_item (last_of_item)
    );

endmodule

[sv/slx_front.sv]
// Lexer front: classifies each request and builds its bundle of records.
module slx_front #(
    parameter int KEYWORD_MAX_LEN = 9,
    parameter int LINE_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         source_byte,
    input  logic               end_of_input,
    input  logic               cfg_write,
    input  logic [23:0]        cfg_data,
    output logic               push,
    output slx_pkg::bundle_t   push_data
);

    localparam int LEN_W = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);

    typedef enum logic [4:0] {
        M_START, M_COMMENT,
        M_TILDE, M_MINUS, M_PLUS, M_STAR, M_STAR2, M_SLASH, M_PERCENT, M_AMP,
        M_PIPE, M_CARET, M_EQ, M_LT, M_LT2, M_LTEQ, M_GT, M_GT2, M_BANG, M_COLON,
        M_IDENT, M_ZERO, M_DIGITS, M_AFTER_INT, M_FRACTION, M_HEX, M_BIN,
        M_STRING, M_ESCAPE
    } mode_t;

    typedef struct packed {
        logic       valid;
        logic [6:0] alone;
        logic [7:0] c1;
        logic [6:0] t1;
        logic       g1;
        mode_t      m1;
        logic [7:0] c2;
        logic [6:0] t2;
        logic       g2;
        mode_t      m2;
    } op_t;

    function automatic logic is_ws(logic [7:0] c);
        return c == slx_pkg::CH_SPACE || c == slx_pkg::CH_TAB || c == slx_pkg::CH_LF
            || c == slx_pkg::CH_VT || c == slx_pkg::CH_FF || c == slx_pkg::CH_CR;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic slx_pkg::rec_t mk_rec(logic [1:0] k, logic [6:0] t,
                                            logic [7:0] c, logic [2:0] e);
        slx_pkg::rec_t r;
        r.kind = k;
        r.tok = t;
        r.ch = c;
        r.err = e;
        return r;
    endfunction

    mode_t                 mode_reg, mode_next;
    logic [7:0]            buf_reg [KEYWORD_MAX_LEN];
    logic [7:0]            buf_next [KEYWORD_MAX_LEN];
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [23:0]           start_reg;
    logic [1:0]            lcount_reg, lcount_next;
    logic                  qs_reg, qs_next;
    logic                  stop_reg, stop_next;

    logic [LINE_BITS+23:0] start_wide, cfg_wide, line_wide;
    logic [6:0]            ident_tok;
    logic                  kw_hit;
    op_t                   op;

    // start-of-token decode
    logic                  sc_rec_v, sc_ws, sc_alpha, sc_quote, sc_fail;
    slx_pkg::rec_t         sc_rec;
    mode_t                 sc_mode;

    slx_pkg::rec_t [slx_pkg::NUM_RECS-1:0] recs;
    logic [1:0]            nrec;
    logic                  redo, run_start, lf, failed;
    logic [7:0]            ch, qchar;

    // widen line values both ways
    assign start_wide = {{LINE_BITS{1'b0}}, start_reg};
    assign cfg_wide   = {{LINE_BITS{1'b0}}, cfg_data};
    assign line_wide  = {24'd0, line_reg};

    // keyword lookup on the held identifier
    always_comb
    begin
        ident_tok = slx_pkg::TOK_IDENT;
        for (int k = 0; k < slx_pkg::NUM_KW; k++)
        begin
            kw_hit = (int'(len_reg) == slx_pkg::KW_LEN[k]);
            for (int p = 0; p < KEYWORD_MAX_LEN; p++)
            begin
                if (p < slx_pkg::KW_LEN[k] && buf_reg[p] != slx_pkg::kw_byte(k, p))
                begin
                    kw_hit = 1'b0;
                end
            end
            if (kw_hit)
            begin
                ident_tok = slx_pkg::TOK_KW_BASE + 7'(k);
            end
        end
    end

    // operator continuation table
    always_comb
    begin
        unique case (mode_reg)
            M_TILDE:   op = '{1'b1, slx_pkg::TOK_TILDE, "~", slx_pkg::TOK_TILDE2, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            M_MINUS:   op = '{1'b1, slx_pkg::TOK_MINUS, "=", slx_pkg::TOK_MINUS_EQ, 1'b0,
                              M_START, ">", slx_pkg::TOK_ARROW, 1'b0, M_START};
            M_PLUS:    op = '{1'b1, slx_pkg::TOK_PLUS, "=", slx_pkg::TOK_PLUS_EQ, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            M_STAR:    op = '{1'b1, slx_pkg::TOK_STAR, "*", 7'd0, 1'b1,
                              M_STAR2, "=", slx_pkg::TOK_STAR_EQ, 1'b0, M_START};
            M_STAR2:   op = '{1'b1, slx_pkg::TOK_POW, "=", slx_pkg::TOK_POW_EQ, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            M_SLASH:   op = '{1'b1, slx_pkg::TOK_SLASH, "=", slx_pkg::TOK_SLASH_EQ, 1'b0,
                              M_START, "/", 7'd0, 1'b1, M_COMMENT};
            M_PERCENT: op = '{1'b1, slx_pkg::TOK_PERCENT, "=", slx_pkg::TOK_PERCENT_EQ, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            M_AMP:     op = '{1'b1, slx_pkg::TOK_AMP, "&", slx_pkg::TOK_AMP2, 1'b0,
                              M_START, "=", slx_pkg::TOK_AMP_EQ, 1'b0, M_START};
            M_PIPE:    op = '{1'b1, slx_pkg::TOK_PIPE, "|", slx_pkg::TOK_PIPE2, 1'b0,
                              M_START, "=", slx_pkg::TOK_PIPE_EQ, 1'b0, M_START};
            M_CARET:   op = '{1'b1, slx_pkg::TOK_CARET, "=", slx_pkg::TOK_CARET_EQ, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            M_EQ:      op = '{1'b1, slx_pkg::TOK_ASSIGN, "=", slx_pkg::TOK_EQ, 1'b0,
                              M_START, ">", slx_pkg::TOK_FAT_ARROW, 1'b0, M_START};
            M_LT:      op = '{1'b1, slx_pkg::TOK_LT, "<", 7'd0, 1'b1,
                              M_LT2, "=", 7'd0, 1'b1, M_LTEQ};
            M_LT2:     op = '{1'b1, slx_pkg::TOK_SHL, "=", slx_pkg::TOK_SHL_EQ, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            M_LTEQ:    op = '{1'b1, slx_pkg::TOK_LE, ">", slx_pkg::TOK_SPACESHIP, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            M_GT:      op = '{1'b1, slx_pkg::TOK_GT, ">", 7'd0, 1'b1,
                              M_GT2, "=", slx_pkg::TOK_GE, 1'b0, M_START};
            M_GT2:     op = '{1'b1, slx_pkg::TOK_SHR, "=", slx_pkg::TOK_SHR_EQ, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            M_BANG:    op = '{1'b1, slx_pkg::TOK_BANG, "=", slx_pkg::TOK_NE, 1'b0,
                              M_START, "~", slx_pkg::TOK_BANG_TILDE, 1'b0, M_START};
            M_COLON:   op = '{1'b1, slx_pkg::TOK_COLON, ":", slx_pkg::TOK_SCOPE, 1'b0,
                              M_START, 8'd0, 7'd0, 1'b0, M_START};
            default:   op = '0;
        endcase
    end

    // decode a byte that opens a token
    always_comb
    begin
        sc_rec_v = 1'b0;
        sc_rec   = '0;
        sc_mode  = M_START;
        sc_ws    = 1'b0;
        sc_alpha = 1'b0;
        sc_quote = 1'b0;
        sc_fail  = 1'b0;
        case (source_byte)
            ",": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_COMMA, 8'd0, 3'd0);
            ";": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_SEMI, 8'd0, 3'd0);
            "(": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_LPAREN, 8'd0, 3'd0);
            ")": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_RPAREN, 8'd0, 3'd0);
            "{": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_LBRACE, 8'd0, 3'd0);
            "}": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_RBRACE, 8'd0, 3'd0);
            "[": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_LBRACK, 8'd0, 3'd0);
            "]": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_RBRACK, 8'd0, 3'd0);
            "_": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_UNDERSCORE, 8'd0, 3'd0);
            "@": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_AT, 8'd0, 3'd0);
            "?": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_QUESTION, 8'd0, 3'd0);
            ".": sc_rec = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_DOT, 8'd0, 3'd0);
            "~": sc_mode = M_TILDE;
            "-": sc_mode = M_MINUS;
            "+": sc_mode = M_PLUS;
            "*": sc_mode = M_STAR;
            "/": sc_mode = M_SLASH;
            "%": sc_mode = M_PERCENT;
            "&": sc_mode = M_AMP;
            "|": sc_mode = M_PIPE;
            "^": sc_mode = M_CARET;
            "=": sc_mode = M_EQ;
            "<": sc_mode = M_LT;
            ">": sc_mode = M_GT;
            "!": sc_mode = M_BANG;
            ":": sc_mode = M_COLON;
            "0": sc_mode = M_ZERO;
            slx_pkg::CH_DQUOTE, slx_pkg::CH_SQUOTE:
            begin
                sc_quote = 1'b1;
                sc_mode  = M_STRING;
            end
            default:
            begin
                if (is_ws(source_byte))
                begin
                    sc_ws = 1'b1;
                end
                else if (is_alpha(source_byte))
                begin
                    sc_alpha = 1'b1;
                    sc_rec   = mk_rec(slx_pkg::REC_TEXT, 7'd0, source_byte, 3'd0);
                    sc_mode  = M_IDENT;
                end
                else if (is_digit(source_byte))
                begin
                    sc_rec  = mk_rec(slx_pkg::REC_TEXT, 7'd0, source_byte, 3'd0);
                    sc_mode = M_DIGITS;
                end
                else
                begin
                    sc_fail = 1'b1;
                    sc_rec  = mk_rec(slx_pkg::REC_ERROR, 7'd0, 8'd0, slx_pkg::ERR_INVALID);
                end
            end
        endcase
        sc_rec_v = sc_rec.kind != slx_pkg::REC_TEXT || sc_alpha || sc_mode == M_DIGITS
                   || sc_fail || (sc_mode == M_START && !sc_ws);
    end

    // advance the lexer over one request
    always_comb
    begin
        mode_next   = mode_reg;
        buf_next    = buf_reg;
        len_next    = len_reg;
        line_next   = line_reg;
        lcount_next = lcount_reg;
        qs_next     = qs_reg;
        stop_next   = stop_reg;
        recs        = '0;
        nrec        = 2'd0;
        redo        = 1'b0;
        run_start   = 1'b0;
        lf          = 1'b0;
        failed      = 1'b0;
        ch          = source_byte;
        qchar       = qs_reg ? slx_pkg::CH_SQUOTE : slx_pkg::CH_DQUOTE;

        if (end_of_input)
        begin
            // flush the pending token, then EOF, or report an open string or escape
            if (op.valid)
            begin
                recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, op.alone, 8'd0, 3'd0);
                nrec = nrec + 2'd1;
            end
            else
            begin
                unique case (mode_reg)
                    M_IDENT:
                    begin
                        recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, ident_tok, 8'd0, 3'd0);
                        nrec = nrec + 2'd1;
                    end
                    M_ZERO:
                    begin
                        recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0, "0", 3'd0);
                        nrec = nrec + 2'd1;
                        recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_INT, 8'd0, 3'd0);
                        nrec = nrec + 2'd1;
                    end
                    M_DIGITS, M_AFTER_INT:
                    begin
                        recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_INT, 8'd0, 3'd0);
                        nrec = nrec + 2'd1;
                    end
                    M_FRACTION:
                    begin
                        recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_FLOAT, 8'd0, 3'd0);
                        nrec = nrec + 2'd1;
                    end
                    M_HEX:
                    begin
                        recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_HEX, 8'd0, 3'd0);
                        nrec = nrec + 2'd1;
                    end
                    M_BIN:
                    begin
                        recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_BIN, 8'd0, 3'd0);
                        nrec = nrec + 2'd1;
                    end
                    M_STRING:
                    begin
                        failed = 1'b1;
                        recs[nrec] = mk_rec(slx_pkg::REC_ERROR, 7'd0, 8'd0,
                                            slx_pkg::ERR_UNTERMINATED);
                        nrec = nrec + 2'd1;
                    end
                    M_ESCAPE:
                    begin
                        failed = 1'b1;
                        recs[nrec] = mk_rec(slx_pkg::REC_ERROR, 7'd0, 8'd0,
                                            slx_pkg::ERR_BAD_ESCAPE);
                        nrec = nrec + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (failed)
            begin
                stop_next = 1'b1;
            end
            else
            begin
                recs[nrec]  = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_EOF, 8'd0, 3'd0);
                nrec        = nrec + 2'd1;
                mode_next   = M_START;
                len_next    = '0;
                line_next   = start_wide[LINE_BITS-1:0];
                lcount_next = 2'd0;
                qs_next     = 1'b0;
            end
        end
        else
        begin
            if (op.valid)
            begin
                // extend or end an operator
                if (is_ws(ch))
                begin
                    lf = (ch == slx_pkg::CH_LF);
                end
                else if (ch == op.c1)
                begin
                    if (op.g1)
                    begin
                        mode_next = op.m1;
                    end
                    else
                    begin
                        recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, op.t1, 8'd0, 3'd0);
                        nrec = nrec + 2'd1;
                        mode_next = M_START;
                    end
                end
                else if (op.c2 != 8'd0 && ch == op.c2)
                begin
                    if (op.g2)
                    begin
                        mode_next = op.m2;
                    end
                    else
                    begin
                        recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, op.t2, 8'd0, 3'd0);
                        nrec = nrec + 2'd1;
                        mode_next = M_START;
                    end
                end
                else
                begin
                    recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, op.alone, 8'd0, 3'd0);
                    nrec = nrec + 2'd1;
                    mode_next = M_START;
                    redo = 1'b1;
                end
            end
            else
            begin
                unique case (mode_reg)
                    M_START:
                    begin
                        run_start = 1'b1;
                    end
                    M_COMMENT:
                    begin
                        if (ch == slx_pkg::CH_LF)
                        begin
                            mode_next = M_START;
                            redo = 1'b1;
                        end
                    end
                    M_IDENT:
                    begin
                        if (is_alpha(ch) || is_digit(ch) || ch == "_")
                        begin
                            if (int'(len_reg) < KEYWORD_MAX_LEN)
                            begin
                                buf_next[len_reg[IDX_W-1:0]] = ch;
                            end
                            if (int'(len_reg) <= KEYWORD_MAX_LEN)
                            begin
                                len_next = len_reg + 1'b1;
                            end
                            recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0, ch, 3'd0);
                            nrec = nrec + 2'd1;
                        end
                        else
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, ident_tok, 8'd0, 3'd0);
                            nrec = nrec + 2'd1;
                            mode_next = M_START;
                            redo = 1'b1;
                        end
                    end
                    M_ZERO:
                    begin
                        if (is_ws(ch))
                        begin
                            lf = (ch == slx_pkg::CH_LF);
                        end
                        else if (ch == "x")
                        begin
                            mode_next = M_HEX;
                        end
                        else if (ch == "b")
                        begin
                            mode_next = M_BIN;
                        end
                        else
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0, "0", 3'd0);
                            nrec = nrec + 2'd1;
                            if (is_digit(ch) || ch == ".")
                            begin
                                recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0, ch, 3'd0);
                                nrec = nrec + 2'd1;
                                mode_next = is_digit(ch) ? M_DIGITS : M_FRACTION;
                            end
                            else
                            begin
                                recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_INT,
                                                    8'd0, 3'd0);
                                nrec = nrec + 2'd1;
                                mode_next = M_START;
                                redo = 1'b1;
                            end
                        end
                    end
                    M_DIGITS, M_AFTER_INT:
                    begin
                        if (is_digit(ch) && mode_reg == M_DIGITS)
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0, ch, 3'd0);
                            nrec = nrec + 2'd1;
                        end
                        else if (is_ws(ch))
                        begin
                            lf = (ch == slx_pkg::CH_LF);
                            mode_next = M_AFTER_INT;
                        end
                        else if (ch == ".")
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0, ch, 3'd0);
                            nrec = nrec + 2'd1;
                            mode_next = M_FRACTION;
                        end
                        else
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TOKEN, slx_pkg::TOK_INT,
                                                8'd0, 3'd0);
                            nrec = nrec + 2'd1;
                            mode_next = M_START;
                            redo = 1'b1;
                        end
                    end
                    M_FRACTION, M_HEX, M_BIN:
                    begin
                        if ((mode_reg == M_FRACTION && is_digit(ch))
                            || (mode_reg == M_HEX && is_hex(ch))
                            || (mode_reg == M_BIN && (ch == "0" || ch == "1")))
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0, ch, 3'd0);
                            nrec = nrec + 2'd1;
                        end
                        else
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TOKEN,
                                mode_reg == M_FRACTION ? slx_pkg::TOK_FLOAT :
                                mode_reg == M_HEX ? slx_pkg::TOK_HEX : slx_pkg::TOK_BIN,
                                8'd0, 3'd0);
                            nrec = nrec + 2'd1;
                            mode_next = M_START;
                            redo = 1'b1;
                        end
                    end
                    M_STRING:
                    begin
                        if (ch == qchar)
                        begin
                            if (qs_reg && lcount_reg != 2'd1)
                            begin
                                failed = 1'b1;
                                recs[nrec] = mk_rec(slx_pkg::REC_ERROR, 7'd0, 8'd0,
                                                    slx_pkg::ERR_NOT_SINGLE);
                                nrec = nrec + 2'd1;
                            end
                            else
                            begin
                                recs[nrec] = mk_rec(slx_pkg::REC_TOKEN,
                                    qs_reg ? slx_pkg::TOK_CHAR : slx_pkg::TOK_STRING,
                                    8'd0, 3'd0);
                                nrec = nrec + 2'd1;
                                mode_next = M_START;
                            end
                        end
                        else if (ch == slx_pkg::CH_LF || ch == slx_pkg::CH_TAB)
                        begin
                            failed = 1'b1;
                            recs[nrec] = mk_rec(slx_pkg::REC_ERROR, 7'd0, 8'd0,
                                ch == slx_pkg::CH_LF ? slx_pkg::ERR_NEWLINE : slx_pkg::ERR_TAB);
                            nrec = nrec + 2'd1;
                        end
                        else if (ch == slx_pkg::CH_BSLASH)
                        begin
                            mode_next = M_ESCAPE;
                        end
                        else
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0, ch, 3'd0);
                            nrec = nrec + 2'd1;
                            if (lcount_reg != 2'd2)
                            begin
                                lcount_next = lcount_reg + 2'd1;
                            end
                        end
                    end
                    M_ESCAPE:
                    begin
                        if (ch == "n" || ch == "t" || ch == slx_pkg::CH_BSLASH || ch == qchar)
                        begin
                            recs[nrec] = mk_rec(slx_pkg::REC_TEXT, 7'd0,
                                ch == "n" ? slx_pkg::CH_LF :
                                ch == "t" ? slx_pkg::CH_TAB : ch, 3'd0);
                            nrec = nrec + 2'd1;
                            mode_next = M_STRING;
                            if (lcount_reg != 2'd2)
                            begin
                                lcount_next = lcount_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            failed = 1'b1;
                            recs[nrec] = mk_rec(slx_pkg::REC_ERROR, 7'd0, 8'd0,
                                                slx_pkg::ERR_BAD_ESCAPE);
                            nrec = nrec + 2'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // the byte that ended a token, or any byte in start mode, opens the next one
            if (redo || run_start)
            begin
                mode_next = sc_mode;
                if (sc_rec_v)
                begin
                    recs[nrec] = sc_rec;
                    nrec = nrec + 2'd1;
                end
                if (sc_quote)
                begin
                    qs_next     = (ch == slx_pkg::CH_SQUOTE);
                    lcount_next = 2'd0;
                end
                if (sc_ws)
                begin
                    lf = (ch == slx_pkg::CH_LF);
                end
                if (sc_alpha)
                begin
                    buf_next[0] = ch;
                    len_next    = LEN_W'(1);
                end
                if (sc_fail)
                begin
                    failed = 1'b1;
                end
            end
            if (failed)
            begin
                stop_next = 1'b1;
            end
            if (lf && line_reg != '1)
            begin
                line_next = line_reg + 1'b1;
            end
        end
    end

    // hand the bundle to the queue
    assign push = take && !stop_reg && nrec != 2'd0;
    always_comb
    begin
        push_data.count = nrec;
        push_data.recs  = recs;
        push_data.line  = line_wide[23:0];
    end

    // hold lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_START;
            len_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            start_reg  <= 24'd1;
            lcount_reg <= 2'd0;
            qs_reg     <= 1'b0;
            stop_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            start_reg <= cfg_data;
            line_reg  <= cfg_wide[LINE_BITS-1:0];
        end
        else if (take && !stop_reg)
        begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            line_reg   <= line_next;
            lcount_reg <= lcount_next;
            qs_reg     <= qs_next;
            stop_reg   <= stop_next;
        end
    end

    // identifier bytes carry no reset
    always_ff @(posedge clk)
    begin
        if (take && !stop_reg)
        begin
            buf_reg <= buf_next;
        end
    end

endmodule

[sv/slx_queue.sv]
// Bundle queue between the lexer front and the record emitter.
module slx_queue #(
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  slx_pkg::bundle_t push_data,
    input  logic             pop,
    output slx_pkg::bundle_t head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    slx_pkg::bundle_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign head  = mem_reg[rd_reg];
    assign empty = cnt_reg == '0;
    assign full  = cnt_reg == CNT_W'(DEPTH);

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

[sv/slx_emit.sv]
// Record emitter: unpacks queued bundles onto the output channel.
module slx_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  slx_pkg::bundle_t head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       record_kind,
    output logic [6:0]       token_kind,
    output logic [7:0]       text_char,
    output logic [2:0]       error_code,
    output logic [23:0]      line_number,
    output logic             last_of_item
);

    slx_pkg::bundle_t bundle_reg;
    logic [1:0]       idx_reg;
    logic             busy_reg;
    logic             sent;
    slx_pkg::rec_t    cur;

    assign cur          = bundle_reg.recs[idx_reg];
    assign out_valid    = busy_reg;
    assign record_kind  = cur.kind;
    assign token_kind   = cur.tok;
    assign text_char    = cur.ch;
    assign error_code   = cur.err;
    assign line_number  = bundle_reg.line;
    assign last_of_item = idx_reg == bundle_reg.count - 2'd1;

    assign sent = busy_reg && !out_stall;
    assign pop  = !empty && (!busy_reg || (sent && last_of_item));

    // step through records, load the next bundle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (sent)
        begin
            if (last_of_item)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // hold the current bundle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bundle_reg <= head;
        end
    end

endmodule

[verif/tb_source_text_lexer.sv]
// Self-checking testbench for the source text lexer: random texts, flow control and checks.
module tb_source_text_lexer;

    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int GO           = 128;
    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    typedef enum int {
        LX_START, LX_COMMENT,
        LX_TILDE, LX_MINUS, LX_PLUS, LX_STAR, LX_STAR2, LX_SLASH, LX_PERCENT, LX_AMP,
        LX_PIPE, LX_CARET, LX_EQ, LX_LT, LX_LT2, LX_LTEQ, LX_GT, LX_GT2, LX_BANG,
        LX_COLON, LX_IDENT, LX_ZERO, LX_DIGITS, LX_AFTER_INT, LX_FRACTION, LX_HEX,
        LX_BIN, LX_STRING, LX_ESCAPE
    } lex_mode_e;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
    } lex_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  tk;
        logic [7:0]  ch;
        logic [2:0]  err;
        logic [23:0] line;
        logic        last;
    } lex_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  source_byte = 8'd0;
    logic        end_of_input = 1'b0;
    logic        cfg_write = 1'b0;
    logic [23:0] cfg_data = 24'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  record_kind;
    logic [6:0]  token_kind;
    logic [7:0]  text_char;
    logic [2:0]  error_code;
    logic [23:0] line_number;
    logic        last_of_item;

    source_text_lexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_byte  (source_byte),
        .end_of_input (end_of_input),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .token_kind   (token_kind),
        .text_char    (text_char),
        .error_code   (error_code),
        .line_number  (line_number),
        .last_of_item (last_of_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // lexer state mirrored by the predictor
    lex_mode_e   lx_mode;
    logic [7:0]  id_buf [9];
    int          id_len;
    logic [23:0] first_line;
    logic [23:0] cur_line;
    logic [7:0]  held;
    int          lit_cnt;
    bit          single_q;
    bit          halted;

    lex_rec_t step_recs[$];
    lex_rec_t expected_recs[$];
    lex_req_t pending_reqs[$];
    int       errors = 0;
    int       hold_req = 0;
    bit       took = 1'b0;

    string kw_names[23] = '{
        "function", "lambda", "while", "for", "return", "var", "if", "else",
        "true", "false", "namespace", "except", "throw", "null", "iife",
        string'({"build", "_in"}), "enum", "define", "preset", "switch", "choose", "case",
        "default"
    };
    string op_names[52] = '{
        ",", ";", "~", "~~", "(", ")", "{", "}", "[", "]", "-", "-=", "->", "+",
        "+=", "*", "**", "**=", "*=", "/", "/=", "%", "%=", "&", "&&", "&=", "|",
        "||", "|=", "^", "^=", "_", "@", "=", "==", "=>", "<", "<<", "<<=", "<=",
        "<=>", ">", ">>", ">>=", ">=", "!", "!=", "!~", "?", ".", ":", "::"
    };

    // ---------------- predictor ----------------

    function automatic void emit(logic [1:0] kind, logic [6:0] tk, logic [7:0] ch,
                                 logic [2:0] err);
        lex_rec_t r;
        if (step_recs.size() >= 4)
        begin
            return;
        end
        r = '{kind: kind, tk: tk, ch: ch, err: err, line: cur_line, last: 1'b0};
        step_recs.insert(step_recs.size(), r);
    endfunction

    function automatic void emit_text(logic [7:0] c);
        emit(slx_pkg::REC_TEXT, slx_pkg::TOK_EOF, c, 3'd0);
    endfunction

    function automatic void emit_tok(logic [6:0] t);
        emit(slx_pkg::REC_TOKEN, t, 8'd0, 3'd0);
    endfunction

    function automatic void emit_err(logic [2:0] e);
        emit(slx_pkg::REC_ERROR, slx_pkg::TOK_EOF, 8'd0, e);
        halted = 1'b1;
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == slx_pkg::CH_SPACE || c == slx_pkg::CH_TAB || c == slx_pkg::CH_LF
            || c == slx_pkg::CH_VT || c == slx_pkg::CH_FF || c == slx_pkg::CH_CR;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // count a line feed, saturating
    function automatic void count_line(logic [7:0] c);
        if (c == slx_pkg::CH_LF && cur_line != LINE_MAX)
        begin
            cur_line++;
        end
    endfunction

    // operator continuation: token alone, then two follow-up bytes and their outcome
    function automatic void op_rule(int idx, output int alone, output int c1,
                                    output int r1, output int c2, output int r2);
        c2 = 0;
        r2 = 0;
        case (idx)
            0:
            begin
                alone = slx_pkg::TOK_TILDE;   c1 = "~"; r1 = slx_pkg::TOK_TILDE2;
            end
            1:
            begin
                alone = slx_pkg::TOK_MINUS;   c1 = "="; r1 = slx_pkg::TOK_MINUS_EQ;
                c2 = ">"; r2 = slx_pkg::TOK_ARROW;
            end
            2:
            begin
                alone = slx_pkg::TOK_PLUS;    c1 = "="; r1 = slx_pkg::TOK_PLUS_EQ;
            end
            3:
            begin
                alone = slx_pkg::TOK_STAR;    c1 = "*"; r1 = GO + int'(LX_STAR2);
                c2 = "="; r2 = slx_pkg::TOK_STAR_EQ;
            end
            4:
            begin
                alone = slx_pkg::TOK_POW;     c1 = "="; r1 = slx_pkg::TOK_POW_EQ;
            end
            5:
            begin
                alone = slx_pkg::TOK_SLASH;   c1 = "="; r1 = slx_pkg::TOK_SLASH_EQ;
                c2 = "/"; r2 = GO + int'(LX_COMMENT);
            end
            6:
            begin
                alone = slx_pkg::TOK_PERCENT; c1 = "="; r1 = slx_pkg::TOK_PERCENT_EQ;
            end
            7:
            begin
                alone = slx_pkg::TOK_AMP;     c1 = "&"; r1 = slx_pkg::TOK_AMP2;
                c2 = "="; r2 = slx_pkg::TOK_AMP_EQ;
            end
            8:
            begin
                alone = slx_pkg::TOK_PIPE;    c1 = "|"; r1 = slx_pkg::TOK_PIPE2;
                c2 = "="; r2 = slx_pkg::TOK_PIPE_EQ;
            end
            9:
            begin
                alone = slx_pkg::TOK_CARET;   c1 = "="; r1 = slx_pkg::TOK_CARET_EQ;
            end
            10:
            begin
                alone = slx_pkg::TOK_ASSIGN;  c1 = "="; r1 = slx_pkg::TOK_EQ;
                c2 = ">"; r2 = slx_pkg::TOK_FAT_ARROW;
            end
            11:
            begin
                alone = slx_pkg::TOK_LT;      c1 = "<"; r1 = GO + int'(LX_LT2);
                c2 = "="; r2 = GO + int'(LX_LTEQ);
            end
            12:
            begin
                alone = slx_pkg::TOK_SHL;     c1 = "="; r1 = slx_pkg::TOK_SHL_EQ;
            end
            13:
            begin
                alone = slx_pkg::TOK_LE;      c1 = ">"; r1 = slx_pkg::TOK_SPACESHIP;
            end
            14:
            begin
                alone = slx_pkg::TOK_GT;      c1 = ">"; r1 = GO + int'(LX_GT2);
                c2 = "="; r2 = slx_pkg::TOK_GE;
            end
            15:
            begin
                alone = slx_pkg::TOK_SHR;     c1 = "="; r1 = slx_pkg::TOK_SHR_EQ;
            end
            16:
            begin
                alone = slx_pkg::TOK_BANG;    c1 = "="; r1 = slx_pkg::TOK_NE;
                c2 = "~"; r2 = slx_pkg::TOK_BANG_TILDE;
            end
            default:
            begin
                alone = slx_pkg::TOK_COLON;   c1 = ":"; r1 = slx_pkg::TOK_SCOPE;
            end
        endcase
    endfunction

    function automatic logic [6:0] ident_token();
        bit hit;
        if (id_len == 0 || id_len > 9)
        begin
            return slx_pkg::TOK_IDENT;
        end
        for (int k = 0; k < 23; k++)
        begin
            hit = kw_names[k].len() == id_len;
            for (int i = 0; i < id_len && hit; i++)
            begin
                hit = kw_names[k][i] == id_buf[i];
            end
            if (hit)
            begin
                return slx_pkg::TOK_KW_BASE + 7'(k);
            end
        end
        return slx_pkg::TOK_IDENT;
    endfunction

    function automatic void restart_text();
        lx_mode = LX_START;
        foreach (id_buf[i])
        begin
            id_buf[i] = 8'd0;
        end
        id_len   = 0;
        cur_line = first_line;
        held     = 8'd0;
        lit_cnt  = 0;
        single_q = 1'b0;
    endfunction

    function automatic void start_token(logic [7:0] c);
        case (c)
            ",": emit_tok(slx_pkg::TOK_COMMA);
            ";": emit_tok(slx_pkg::TOK_SEMI);
            "(": emit_tok(slx_pkg::TOK_LPAREN);
            ")": emit_tok(slx_pkg::TOK_RPAREN);
            "{": emit_tok(slx_pkg::TOK_LBRACE);
            "}": emit_tok(slx_pkg::TOK_RBRACE);
            "[": emit_tok(slx_pkg::TOK_LBRACK);
            "]": emit_tok(slx_pkg::TOK_RBRACK);
            "_": emit_tok(slx_pkg::TOK_UNDERSCORE);
            "@": emit_tok(slx_pkg::TOK_AT);
            "?": emit_tok(slx_pkg::TOK_QUESTION);
            ".": emit_tok(slx_pkg::TOK_DOT);
            "~": lx_mode = LX_TILDE;
            "-": lx_mode = LX_MINUS;
            "+": lx_mode = LX_PLUS;
            "*": lx_mode = LX_STAR;
            "/": lx_mode = LX_SLASH;
            "%": lx_mode = LX_PERCENT;
            "&": lx_mode = LX_AMP;
            "|": lx_mode = LX_PIPE;
            "^": lx_mode = LX_CARET;
            "=": lx_mode = LX_EQ;
            "<": lx_mode = LX_LT;
            ">": lx_mode = LX_GT;
            "!": lx_mode = LX_BANG;
            ":": lx_mode = LX_COLON;
            slx_pkg::CH_DQUOTE, slx_pkg::CH_SQUOTE:
            begin
                single_q = c == slx_pkg::CH_SQUOTE;
                lit_cnt  = 0;
                lx_mode  = LX_STRING;
            end
            "0":
            begin
                held    = "0";
                lx_mode = LX_ZERO;
            end
            default:
            begin
                if (is_ws(c))
                begin
                    count_line(c);
                end
                else if (is_alpha(c))
                begin
                    id_buf[0] = c;
                    id_len    = 1;
                    emit_text(c);
                    lx_mode   = LX_IDENT;
                end
                else if (is_digit(c))
                begin
                    emit_text(c);
                    lx_mode = LX_DIGITS;
                end
                else
                begin
                    emit_err(slx_pkg::ERR_INVALID);
                end
            end
        endcase
    endfunction

    // consume one byte; 1 means the byte must be seen again from the start mode
    function automatic bit take_byte(logic [7:0] c_in);
        int alone, c1, r1, c2, r2, res;
        logic [7:0] q, c;
        bit literal;
        c       = c_in;
        literal = 1'b0;
        q       = single_q ? slx_pkg::CH_SQUOTE : slx_pkg::CH_DQUOTE;
        if (lx_mode >= LX_TILDE && lx_mode <= LX_COLON)
        begin
            op_rule(int'(lx_mode) - int'(LX_TILDE), alone, c1, r1, c2, r2);
            if (is_ws(c))
            begin
                count_line(c);
                return 1'b0;
            end
            if (c == c1)
            begin
                res = r1;
            end
            else if (c2 != 0 && c == c2)
            begin
                res = r2;
            end
            else
            begin
                emit_tok(7'(alone));
                lx_mode = LX_START;
                return 1'b1;
            end
            if (res >= GO)
            begin
                lx_mode = lex_mode_e'(res - GO);
            end
            else
            begin
                emit_tok(7'(res));
                lx_mode = LX_START;
            end
            return 1'b0;
        end
        case (lx_mode)
            LX_COMMENT:
            begin
                if (c == slx_pkg::CH_LF)
                begin
                    lx_mode = LX_START;
                    return 1'b1;
                end
                return 1'b0;
            end
            LX_IDENT:
            begin
                if (is_alpha(c) || is_digit(c) || c == "_")
                begin
                    if (id_len < 9)
                    begin
                        id_buf[id_len] = c;
                    end
                    if (id_len <= 9)
                    begin
                        id_len++;
                    end
                    emit_text(c);
                    return 1'b0;
                end
                emit_tok(ident_token());
                lx_mode = LX_START;
                return 1'b1;
            end
            LX_ZERO:
            begin
                if (is_ws(c))
                begin
                    count_line(c);
                    return 1'b0;
                end
                if (c == "x")
                begin
                    lx_mode = LX_HEX;
                    return 1'b0;
                end
                if (c == "b")
                begin
                    lx_mode = LX_BIN;
                    return 1'b0;
                end
                emit_text(held);
                if (is_digit(c))
                begin
                    emit_text(c);
                    lx_mode = LX_DIGITS;
                    return 1'b0;
                end
                if (c == ".")
                begin
                    emit_text(c);
                    lx_mode = LX_FRACTION;
                    return 1'b0;
                end
                emit_tok(slx_pkg::TOK_INT);
                lx_mode = LX_START;
                return 1'b1;
            end
            LX_DIGITS, LX_AFTER_INT:
            begin
                if (lx_mode == LX_DIGITS && is_digit(c))
                begin
                    emit_text(c);
                    return 1'b0;
                end
                if (is_ws(c))
                begin
                    count_line(c);
                    lx_mode = LX_AFTER_INT;
                    return 1'b0;
                end
                if (c == ".")
                begin
                    emit_text(c);
                    lx_mode = LX_FRACTION;
                    return 1'b0;
                end
                emit_tok(slx_pkg::TOK_INT);
                lx_mode = LX_START;
                return 1'b1;
            end
            LX_FRACTION, LX_HEX, LX_BIN:
            begin
                if ((lx_mode == LX_FRACTION && is_digit(c))
                    || (lx_mode == LX_HEX && is_hex(c))
                    || (lx_mode == LX_BIN && (c == "0" || c == "1")))
                begin
                    emit_text(c);
                    return 1'b0;
                end
                emit_tok(lx_mode == LX_FRACTION ? slx_pkg::TOK_FLOAT
                         : lx_mode == LX_HEX ? slx_pkg::TOK_HEX : slx_pkg::TOK_BIN);
                lx_mode = LX_START;
                return 1'b1;
            end
            LX_STRING:
            begin
                if (c == q)
                begin
                    if (single_q && lit_cnt != 1)
                    begin
                        emit_err(slx_pkg::ERR_NOT_SINGLE);
                        return 1'b0;
                    end
                    emit_tok(single_q ? slx_pkg::TOK_CHAR : slx_pkg::TOK_STRING);
                    lx_mode = LX_START;
                    return 1'b0;
                end
                if (c == slx_pkg::CH_LF)
                begin
                    emit_err(slx_pkg::ERR_NEWLINE);
                    return 1'b0;
                end
                if (c == slx_pkg::CH_TAB)
                begin
                    emit_err(slx_pkg::ERR_TAB);
                    return 1'b0;
                end
                if (c == slx_pkg::CH_BSLASH)
                begin
                    lx_mode = LX_ESCAPE;
                    return 1'b0;
                end
                literal = 1'b1;
            end
            LX_ESCAPE:
            begin
                if (c == "n")
                begin
                    c = slx_pkg::CH_LF;
                end
                else if (c == "t")
                begin
                    c = slx_pkg::CH_TAB;
                end
                else if (c != slx_pkg::CH_BSLASH && c != q)
                begin
                    emit_err(slx_pkg::ERR_BAD_ESCAPE);
                    return 1'b0;
                end
                lx_mode = LX_STRING;
                literal = 1'b1;
            end
            default:
            begin
                lx_mode = LX_START;
                start_token(c);
            end
        endcase
        if (literal)
        begin
            emit_text(c);
            if (lit_cnt < 2)
            begin
                lit_cnt++;
            end
        end
        return 1'b0;
    endfunction

    // end of text: flush the pending token, then EOF, or flag an open string or escape
    function automatic void end_text();
        int alone, c1, r1, c2, r2;
        if (lx_mode >= LX_TILDE && lx_mode <= LX_COLON)
        begin
            op_rule(int'(lx_mode) - int'(LX_TILDE), alone, c1, r1, c2, r2);
            emit_tok(7'(alone));
        end
        else
        begin
            case (lx_mode)
                LX_IDENT: emit_tok(ident_token());
                LX_ZERO:
                begin
                    emit_text(held);
                    emit_tok(slx_pkg::TOK_INT);
                end
                LX_DIGITS, LX_AFTER_INT: emit_tok(slx_pkg::TOK_INT);
                LX_FRACTION: emit_tok(slx_pkg::TOK_FLOAT);
                LX_HEX: emit_tok(slx_pkg::TOK_HEX);
                LX_BIN: emit_tok(slx_pkg::TOK_BIN);
                LX_STRING:
                begin
                    emit_err(slx_pkg::ERR_UNTERMINATED);
                    return;
                end
                LX_ESCAPE:
                begin
                    emit_err(slx_pkg::ERR_BAD_ESCAPE);
                    return;
                end
                default: ;
            endcase
        end
        emit_tok(slx_pkg::TOK_EOF);
        restart_text();
    endfunction

    function automatic void predict_request(lex_req_t req);
        step_recs.delete();
        if (!halted)
        begin
            if (req.e)
            begin
                end_text();
            end
            else if (take_byte(req.b) && !halted)
            begin
                void'(take_byte(req.b));
            end
        end
        if (step_recs.size() > 0)
        begin
            step_recs[$].last = 1'b1;
        end
        foreach (step_recs[i])
        begin
            expected_recs.insert(expected_recs.size(), step_recs[i]);
        end
    endfunction

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        lex_rec_t x;
        took = in_valid && !in_stall;
        if (out_valid && !out_stall)
        begin
            if (expected_recs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected record kind %0d tok %0d char %0h err %0d line %0d",
                         $time, record_kind, token_kind, text_char, error_code, line_number);
            end
            else
            begin
                x = expected_recs.pop_front();
                if (record_kind !== x.kind || token_kind !== x.tk || text_char !== x.ch
                    || error_code !== x.err || line_number !== x.line
                    || last_of_item !== x.last)
                begin
                    errors++;
                    $display("%0t: expected kind %0d tok %0d char %0h err %0d line %0d last %0b",
                             $time, x.kind, x.tk, x.ch, x.err, x.line, x.last);
                    $display("%0t: actual   kind %0d tok %0d char %0h err %0d line %0d last %0b",
                             $time, record_kind, token_kind, text_char, error_code,
                             line_number, last_of_item);
                end
            end
        end
        if (took)
        begin
            predict_request('{b: source_byte, e: end_of_input});
        end
    end

    // ---------------- sender: bursts and gaps ----------------

    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        lex_req_t req;
        if (!in_valid || took)
        begin
            if (gap_left > 0 || pending_reqs.size() == 0 || !rst_n)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                in_valid <= 1'b0;
            end
            else
            begin
                req = pending_reqs.pop_front();
                source_byte  <= req.b;
                end_of_input <= req.e;
                in_valid     <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // ---------------- receiver: stall regimes and long hold ----------------

    int hold_seen = 0;
    int hold_left = 0;
    int regime = 0;
    int regime_left = 0;

    always @(negedge clk)
    begin
        bit s;
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (regime_left == 0)
        begin
            regime      = $urandom_range(0, 2);
            regime_left = $urandom_range(5, 40);
        end
        regime_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            s = 1'b1;
        end
        else
        begin
            case (regime)
                0: s = 1'b0;
                1: s = $urandom_range(0, 3) == 0;
                default: s = $urandom_range(0, 3) != 0;
            endcase
        end
        out_stall <= s;
    end

    // ---------------- stimulus ----------------

    int gen_count = 0;

    task automatic put_byte(logic [7:0] b);
        lex_req_t r;
        r = '{b: b, e: 1'b0};
        pending_reqs.insert(pending_reqs.size(), r);
        gen_count++;
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_byte(s[i]);
        end
    endtask

    // the byte under an end mark is ignored, so any value goes
    task automatic put_end();
        lex_req_t r;
        r = '{b: 8'($urandom_range(0, 255)), e: 1'b1};
        pending_reqs.insert(pending_reqs.size(), r);
        gen_count++;
    endtask

    task automatic put_ws();
        case ($urandom_range(0, 5))
            0: put_byte(slx_pkg::CH_TAB);
            1: put_byte(slx_pkg::CH_LF);
            2: put_byte(slx_pkg::CH_VT);
            3: put_byte(slx_pkg::CH_FF);
            4: put_byte(slx_pkg::CH_CR);
            default: put_byte(slx_pkg::CH_SPACE);
        endcase
    endtask

    task automatic put_ident_char();
        case ($urandom_range(0, 3))
            0: put_byte(8'($urandom_range("0", "9")));
            1: put_byte("_");
            2: put_byte(8'($urandom_range("A", "Z")));
            default: put_byte(8'($urandom_range("a", "z")));
        endcase
    endtask

    // any byte a string may carry as plain text
    task automatic put_string_body(logic [7:0] q);
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0:
            begin
                put_byte(slx_pkg::CH_BSLASH);
                case ($urandom_range(0, 3))
                    0: put_byte("n");
                    1: put_byte("t");
                    2: put_byte(slx_pkg::CH_BSLASH);
                    default: put_byte(q);
                endcase
            end
            1: put_byte(8'($urandom_range(128, 255)));
            default:
            begin
                do
                begin
                    b = 8'($urandom_range(0, 127));
                end
                while (b == q || b == slx_pkg::CH_BSLASH || b == slx_pkg::CH_LF
                       || b == slx_pkg::CH_TAB);
                put_byte(b);
            end
        endcase
    endtask

    task automatic put_token();
        logic [7:0] b;
        string s;
        int n;
        case ($urandom_range(0, 10))
            0: put_str(kw_names[$urandom_range(0, 22)]);
            1:
            begin
                put_byte(8'($urandom_range("a", "z")));
                n = $urandom_range(0, 11);
                repeat (n) put_ident_char();
            end
            2:
            begin
                put_byte(8'($urandom_range("1", "9")));
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range("0", "9")));
                if ($urandom_range(0, 2) == 0)
                begin
                    if ($urandom_range(0, 1)) put_ws();
                    put_byte(".");
                    repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range("0", "9")));
                end
            end
            3:
            begin
                put_byte("0");
                if ($urandom_range(0, 2) == 0) put_ws();
                case ($urandom_range(0, 3))
                    0:
                    begin
                        put_byte("x");
                        s = "0123456789abcdefABCDEF";
                        repeat ($urandom_range(0, 4)) put_byte(s[$urandom_range(0, 21)]);
                    end
                    1:
                    begin
                        put_byte("b");
                        repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range("0", "1")));
                    end
                    2:
                    begin
                        put_byte(".");
                        put_byte(8'($urandom_range("0", "9")));
                    end
                    default: ;
                endcase
            end
            4, 5:
            begin
                s = op_names[$urandom_range(0, 51)];
                for (int i = 0; i < s.len(); i++)
                begin
                    if (i > 0 && $urandom_range(0, 4) == 0) put_ws();
                    put_byte(s[i]);
                end
            end
            6:
            begin
                put_byte(slx_pkg::CH_DQUOTE);
                repeat ($urandom_range(0, 5)) put_string_body(slx_pkg::CH_DQUOTE);
                put_byte(slx_pkg::CH_DQUOTE);
            end
            7:
            begin
                put_byte(slx_pkg::CH_SQUOTE);
                put_string_body(slx_pkg::CH_SQUOTE);
                put_byte(slx_pkg::CH_SQUOTE);
            end
            8:
            begin
                put_str("//");
                repeat ($urandom_range(0, 6))
                begin
                    do
                    begin
                        b = 8'($urandom_range(0, 255));
                    end
                    while (b == slx_pkg::CH_LF);
                    put_byte(b);
                end
                put_byte(slx_pkg::CH_LF);
            end
            default: put_ws();
        endcase
        if ($urandom_range(0, 1)) put_ws();
    endtask

    // text of roughly the given size, with end marks scattered in it
    task automatic put_random_text(int size);
        int stop;
        stop = gen_count + size;
        while (gen_count < stop)
        begin
            put_token();
            if ($urandom_range(0, 9) == 0) put_end();
        end
        put_end();
    endtask

    // hold until every request is sent and every record has come back
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || expected_recs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_line(logic [23:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write  <= 1'b0;
        first_line = v;
        cur_line   = v;
    endtask

    initial
    begin
        logic [23:0] lines [4];
        first_line = 24'd1;
        halted     = 1'b0;
        restart_text();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: spaced hex and float, spaced operator, escape, char
        put_str("0 x1F 12 .5<=> - =\"\\t\"'a'");
        put_end();
        wait_idle();

        lines = '{LINE_MAX - 24'd1, 24'd0, 24'($urandom_range(2, 1000)), LINE_MAX};
        foreach (lines[i])
        begin
            write_start_line(lines[i]);
            if (i == 1)
            begin
                // long output hold while the sender keeps offering
                hold_req++;
            end
            put_str("a\n\n");
            put_random_text(26);
            wait_idle();
        end

        // close with one error, which stops the lexer for good
        write_start_line(24'($urandom_range(1, 50)));
        put_str("ok ");
        case ($urandom_range(0, 6))
            0: put_str("\"a\\q");
            1: put_str("\"a\n");
            2: put_str("\"a\t");
            3:
            begin
                put_str("\"ab");
                put_end();
            end
            4:
            begin
                put_str("\"a\\");
                put_end();
            end
            5: put_str("'ab'");
            default: put_byte(8'($urandom_range(128, 255)));
        endcase
        repeat (5) put_byte(8'($urandom_range(0, 255)));
        put_end();
        wait_idle();

        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
